### sv/idbc_pkg.sv
// Shared types, codes and constants of the display idle controller.
`timescale 1ns / 1ps
`default_nettype none

package idbc_pkg;

  // Entries of the queue between the event front and the result back.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned LVL_W  = 16;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned MAX_RES = 4;

  localparam int unsigned MS_PER_SEC     = 1000;
  localparam int unsigned PER_MILLE      = 1000;
  localparam int unsigned DIM_LEAD_SECS  = 2;
  localparam int unsigned DIM_FLOOR      = 5;

  // Millisecond thresholds: 65535 s * 1000 fits in 26 bits.
  localparam int unsigned MS_W   = 26;
  localparam int unsigned PROG_W = 10;
  localparam int unsigned PROD_W = LVL_W + PROG_W;

  // floor(x / 1000) = (x * RECIP_MUL) >> RECIP_SHIFT for any 26-bit x.
  localparam int unsigned RECIP_SHIFT = 36;
  localparam logic [26:0] RECIP_MUL   = 27'd68719477;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TIMEOUT    = 3'd0;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd1;
  localparam logic [2:0] REG_BACKLIGHT  = 3'd2;
  localparam logic [2:0] REG_FB_BLANK   = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_EN = 3'd4;

  typedef enum logic [2:0] {
    ACT_NONE           = 3'd0,
    ACT_SET            = 3'd1,
    ACT_FB_BLANK       = 3'd2,
    ACT_FB_UNBLANK     = 3'd3,
    ACT_BLANK_SCRIPT   = 3'd4,
    ACT_UNBLANK_SCRIPT = 3'd5
  } act_e;

  typedef struct packed {
    logic [LVL_W-1:0] timeout_secs;
    logic [LVL_W-1:0] brightness_setting;
    logic             has_backlight;
    logic             fb_blank_enable;
    logic             timeout_feature;
  } cfg_t;

  // All results of one event; num is the count of valid entries (1..4).
  typedef struct packed {
    logic [MAX_RES-1:0][2:0]       act;
    logic [MAX_RES-1:0][LVL_W-1:0] lvl;
    logic [2:0]                    num;
    logic                          accepted;
    logic                          scr_off;
  } rec_t;

endpackage

`default_nettype wire

### sv/idbc_regs.sv
// Configuration registers behind an APB-style port.
`timescale 1ns / 1ps
`default_nettype none

module idbc_regs import idbc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_secs       <= '0;
      cfg_q.brightness_setting <= 16'd255;
      cfg_q.has_backlight      <= 1'b0;
      cfg_q.fb_blank_enable    <= 1'b1;
      cfg_q.timeout_feature    <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TIMEOUT:    cfg_q.timeout_secs       <= pwdata[LVL_W-1:0];
        REG_BRIGHTNESS: cfg_q.brightness_setting <= pwdata[LVL_W-1:0];
        REG_BACKLIGHT:  cfg_q.has_backlight      <= pwdata[0];
        REG_FB_BLANK:   cfg_q.fb_blank_enable    <= pwdata[0];
        REG_TIMEOUT_EN: cfg_q.timeout_feature    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TIMEOUT:    prdata = 32'(cfg_q.timeout_secs);
      REG_BRIGHTNESS: prdata = 32'(cfg_q.brightness_setting);
      REG_BACKLIGHT:  prdata = 32'(cfg_q.has_backlight);
      REG_FB_BLANK:   prdata = 32'(cfg_q.fb_blank_enable);
      REG_TIMEOUT_EN: prdata = 32'(cfg_q.timeout_feature);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/idbc_front.sv
// Event front: buffers an event, runs the idle timers and dim ramp, emits one result record.
`timescale 1ns / 1ps
`default_nettype none

module idbc_front import idbc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfg_t              cfg_i,
  input  wire logic              ev_valid_i,
  output logic                   ev_ready_o,
  input  wire logic [1:0]        ev_kind_i,
  input  wire logic [TIME_W-1:0] ev_time_i,
  output logic                   rec_valid_o,
  input  wire logic              rec_ready_i,
  output rec_t                   rec_o
);

  typedef enum logic [1:0] {EV_TICK, EV_ACTIVITY, EV_ON, EV_OFF} kind_e;
  typedef enum logic [1:0] {MODE_ON, MODE_DIM, MODE_OFF, MODE_BLANKED} mode_e;
  typedef enum logic [2:0] {F_IDLE, F_RANGE, F_SCALE, F_RECIP, F_COMMIT} fstate_e;

  fstate_e state_q;

  // input buffer
  logic              buf_valid_q;
  logic [1:0]        buf_kind_q;
  logic [TIME_W-1:0] buf_time_q;

  // architectural state
  mode_e             mode_q, mode_d;
  logic [TIME_W-1:0] last_tick_q;
  logic [TIME_W-1:0] last_act_q, last_act_d;
  logic [TIME_W-1:0] dim_start_q, dim_start_d;
  logic [LVL_W-1:0]  ldl_q, ldl_d;
  logic              ldv_q, ldv_d;
  logic [LVL_W-1:0]  saved_lvl_q, saved_lvl_d;
  logic              saved_v_q, saved_v_d;

  // datapath
  logic [1:0]        kind_q;
  logic [TIME_W-1:0] time_q;
  logic [TIME_W-1:0] elapsed_q, elapsed_d;
  logic [TIME_W-1:0] de_q, de_d;
  logic [MS_W-1:0]   to_ms_q, to_ms_d;
  logic [MS_W-1:0]   lead_ms_q, lead_ms_d;
  logic              tick_live_q, tick_live_d;
  logic              dim_enter_q, dim_enter_d;
  logic              blank_due_q, blank_due_d;
  logic [LVL_W-1:0]  start_q, start_d;
  logic [LVL_W-1:0]  span_q;
  logic [PROG_W-1:0] prog_q, prog_d;
  logic [PROD_W-1:0] prod_q;
  logic [LVL_W-1:0]  quot_q;

  logic              sup;
  logic              take;
  logic              commit;
  logic [TIME_W-1:0] la_eff;
  logic [TIME_W:0]   el_diff;
  logic [TIME_W:0]   de_diff;
  logic [TIME_W-2:0] half;
  logic [LVL_W-1:0]  start_raw;
  logic [52:0]       recip_full;
  logic [LVL_W-1:0]  dim_value;
  rec_t              rec_d;

  function automatic rec_t push(rec_t r, act_e a, logic [LVL_W-1:0] l);
    rec_t o;
    o = r;
    if (o.num < 3'(MAX_RES)) begin
      o.act[o.num[1:0]] = a;
      o.lvl[o.num[1:0]] = l;
      o.num             = o.num + 3'd1;
    end
    return o;
  endfunction

  assign sup         = cfg_i.timeout_feature & (cfg_i.fb_blank_enable | cfg_i.has_backlight);
  assign ev_ready_o  = ~buf_valid_q;
  assign take        = (state_q == F_IDLE) & buf_valid_q;
  assign rec_valid_o = (state_q == F_COMMIT);
  assign commit      = rec_valid_o & rec_ready_i;
  assign rec_o       = rec_d;

  // First stage: elapsed times and thresholds, straight from the buffer.
  always_comb begin
    la_eff    = (sup && last_act_q == '0) ? buf_time_q : last_act_q;
    el_diff   = {1'b0, buf_time_q} - {1'b0, la_eff};
    elapsed_d = el_diff[TIME_W] ? '0 : el_diff[TIME_W-1:0];
    de_diff   = {1'b0, buf_time_q} - {1'b0, dim_start_q};
    de_d      = de_diff[TIME_W] ? '0 : de_diff[TIME_W-1:0];
    to_ms_d   = MS_W'(cfg_i.timeout_secs) * MS_W'(MS_PER_SEC);
    lead_ms_d = MS_W'(cfg_i.timeout_secs - LVL_W'(DIM_LEAD_SECS)) * MS_W'(MS_PER_SEC);
  end

  // Second stage: dim entry, blank decision, ramp progress and start level.
  always_comb begin
    tick_live_d = sup && (cfg_i.timeout_secs != '0)
                  && (mode_q == MODE_ON || mode_q == MODE_DIM);
    dim_enter_d = tick_live_d && (cfg_i.timeout_secs > LVL_W'(DIM_LEAD_SECS))
                  && (mode_q == MODE_ON) && (elapsed_q >= TIME_W'(lead_ms_q));
    blank_due_d = tick_live_d && (elapsed_q >= TIME_W'(to_ms_q));
    half        = de_q[TIME_W-1:1];
    if (dim_enter_d) begin
      prog_d = '0;
    end else if (half > (TIME_W-1)'(PER_MILLE)) begin
      prog_d = PROG_W'(PER_MILLE);
    end else begin
      prog_d = half[PROG_W-1:0];
    end
    if (dim_enter_d) begin
      start_raw = cfg_i.has_backlight ? cfg_i.brightness_setting : '0;
    end else begin
      start_raw = saved_v_q ? saved_lvl_q : '0;
    end
    start_d = (start_raw < LVL_W'(DIM_FLOOR)) ? LVL_W'(DIM_FLOOR) : start_raw;
  end

  assign recip_full = 53'(prod_q) * 53'(RECIP_MUL);
  assign dim_value  = start_q - quot_q;

  // Commit: apply the event to the state and build its result list.
  always_comb begin
    logic do_blank;
    logic do_unblank;
    do_blank    = 1'b0;
    do_unblank  = 1'b0;
    mode_d      = mode_q;
    last_act_d  = last_act_q;
    dim_start_d = dim_start_q;
    ldl_d       = ldl_q;
    ldv_d       = ldv_q;
    saved_lvl_d = saved_lvl_q;
    saved_v_d   = saved_v_q;
    rec_d       = '0;
    case (kind_e'(kind_q))
      EV_TICK: begin
        if (tick_live_q) begin
          if (dim_enter_q) begin
            saved_v_d   = cfg_i.has_backlight;
            saved_lvl_d = cfg_i.has_backlight ? cfg_i.brightness_setting : '0;
            mode_d      = MODE_DIM;
            dim_start_d = time_q;
            ldv_d       = 1'b0;
            ldl_d       = '0;
          end
          if (mode_d == MODE_DIM && cfg_i.has_backlight) begin
            if (!ldv_d || dim_value != ldl_d) begin
              rec_d = push(rec_d, ACT_SET, dim_value);
              ldl_d = dim_value;
              ldv_d = 1'b1;
            end
          end
          do_blank = blank_due_q;
        end
      end
      EV_ACTIVITY: begin
        if (sup) begin
          do_unblank = (mode_q != MODE_ON);
          last_act_d = last_tick_q;
        end
      end
      EV_ON: begin
        if (sup) begin
          rec_d.accepted = 1'b1;
          if (mode_q == MODE_ON) begin
            if (cfg_i.fb_blank_enable) rec_d = push(rec_d, ACT_FB_UNBLANK, '0);
            if (cfg_i.has_backlight) begin
              rec_d = push(rec_d, ACT_SET, cfg_i.brightness_setting);
            end
          end else begin
            do_unblank = 1'b1;
          end
          last_act_d = last_tick_q;
        end
      end
      EV_OFF: begin
        if (sup) begin
          rec_d.accepted = 1'b1;
          do_blank       = 1'b1;
        end
      end
      default: ;
    endcase
    if (do_blank && (mode_d == MODE_ON || mode_d == MODE_DIM)) begin
      if (mode_d == MODE_ON) begin
        saved_v_d   = cfg_i.has_backlight;
        saved_lvl_d = cfg_i.has_backlight ? cfg_i.brightness_setting : '0;
      end
      mode_d = MODE_OFF;
      if (cfg_i.has_backlight) rec_d = push(rec_d, ACT_SET, '0);
      rec_d = push(rec_d, ACT_BLANK_SCRIPT, '0);
      if (cfg_i.fb_blank_enable) begin
        rec_d  = push(rec_d, ACT_FB_BLANK, '0);
        mode_d = MODE_BLANKED;
      end
    end
    if (do_unblank) begin
      if (mode_q == MODE_BLANKED) rec_d = push(rec_d, ACT_FB_UNBLANK, '0);
      if (mode_q == MODE_OFF || mode_q == MODE_BLANKED) begin
        rec_d = push(rec_d, ACT_UNBLANK_SCRIPT, '0);
      end
      if (saved_v_q) rec_d = push(rec_d, ACT_SET, saved_lvl_q);
      mode_d      = MODE_ON;
      dim_start_d = '0;
      ldv_d       = 1'b0;
      ldl_d       = '0;
    end
    if (rec_d.num == '0) rec_d = push(rec_d, ACT_NONE, '0);
    rec_d.scr_off = (mode_d == MODE_OFF) || (mode_d == MODE_BLANKED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      buf_valid_q <= 1'b0;
      mode_q      <= MODE_ON;
      last_tick_q <= '0;
      last_act_q  <= '0;
      dim_start_q <= '0;
      ldl_q       <= '0;
      ldv_q       <= 1'b0;
      saved_lvl_q <= '0;
      saved_v_q   <= 1'b0;
    end else begin
      if (ev_valid_i && ev_ready_o) begin
        buf_valid_q <= 1'b1;
      end else if (take) begin
        buf_valid_q <= 1'b0;
      end
      case (state_q)
        F_IDLE: begin
          if (take) begin
            if (kind_e'(buf_kind_q) == EV_TICK) begin
              // record the tick time and start the idle clock on the first one
              last_tick_q <= buf_time_q;
              last_act_q  <= la_eff;
              state_q     <= F_RANGE;
            end else begin
              state_q <= F_COMMIT;
            end
          end
        end
        F_RANGE:  state_q <= F_SCALE;
        F_SCALE:  state_q <= F_RECIP;
        F_RECIP:  state_q <= F_COMMIT;
        F_COMMIT: begin
          if (commit) begin
            mode_q      <= mode_d;
            last_act_q  <= last_act_d;
            dim_start_q <= dim_start_d;
            ldl_q       <= ldl_d;
            ldv_q       <= ldv_d;
            saved_lvl_q <= saved_lvl_d;
            saved_v_q   <= saved_v_d;
            state_q     <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_valid_i && ev_ready_o) begin
      buf_kind_q <= ev_kind_i;
      buf_time_q <= ev_time_i;
    end
    if (take) begin
      kind_q    <= buf_kind_q;
      time_q    <= buf_time_q;
      elapsed_q <= elapsed_d;
      de_q      <= de_d;
      to_ms_q   <= to_ms_d;
      lead_ms_q <= lead_ms_d;
    end
    if (state_q == F_RANGE) begin
      tick_live_q <= tick_live_d;
      dim_enter_q <= dim_enter_d;
      blank_due_q <= blank_due_d;
      start_q     <= start_d;
      span_q      <= start_d - LVL_W'(DIM_FLOOR);
      prog_q      <= prog_d;
    end
    if (state_q == F_SCALE) begin
      prod_q <= PROD_W'(span_q) * PROD_W'(prog_q);
    end
    if (state_q == F_RECIP) begin
      quot_q <= recip_full[RECIP_SHIFT+LVL_W-1:RECIP_SHIFT];
    end
  end

endmodule

`default_nettype wire

### sv/idbc_queue.sv
// Short FIFO of event result records between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module idbc_queue import idbc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire rec_t push_data_i,
  output logic      pop_valid_o,
  input  wire logic pop_i,
  output rec_t      pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rec_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  function automatic logic [PW-1:0] wrap_inc(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wrap_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= wrap_inc(rd_ptr_q);
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

`default_nettype wire

### sv/idbc_back.sv
// Result back: walks a record and drives one result beat per cycle, unless stalled, from an output register.
`timescale 1ns / 1ps
`default_nettype none

module idbc_back import idbc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rec_valid_i,
  input  wire rec_t        rec_i,
  output logic             rec_pop_o,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [2:0]       res_action_o,
  output logic [LVL_W-1:0] res_level_o,
  output logic             res_accepted_o,
  output logic             res_off_o,
  output logic             res_last_o
);

  logic             out_valid_q;
  logic [1:0]       idx_q;
  logic [2:0]       act_q;
  logic [LVL_W-1:0] lvl_q;
  logic             acc_q, off_q, last_q;
  logic             load;
  logic             is_last;

  assign load      = rec_valid_i & (~out_valid_q | res_ready_i);
  assign is_last   = ({1'b0, idx_q} == (rec_i.num - 3'd1));
  assign rec_pop_o = load & is_last;

  assign res_valid_o    = out_valid_q;
  assign res_action_o   = act_q;
  assign res_level_o    = lvl_q;
  assign res_accepted_o = acc_q;
  assign res_off_o      = off_q;
  assign res_last_o     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      act_q  <= rec_i.act[idx_q];
      lvl_q  <= rec_i.lvl[idx_q];
      acc_q  <= rec_i.accepted;
      off_q  <= rec_i.scr_off;
      last_q <= is_last;
    end
  end

endmodule

`default_nettype wire

### sv/idle_dim_blank_controller_unit.sv
// The front walks a tick through its range, scale, reciprocal and commit stages and takes
// any other event straight to commit; results then leave at one beat per cycle while the
// result stream is ready.
// An input buffer and a result queue let new events enter while results drain.
// Reset (rst_ni low, asynchronous) sets mode on, clears all times and saved levels,
// and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module idle_dim_blank_controller_unit import idbc_pkg::*; #(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // event stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [63:0] time_ms
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [15:0] level, [16] accepted, [17] screen_is_off
  output logic [2:0]       m_axis_tuser_o,   // [2:0] action
  output logic             m_axis_tlast_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t             cfg;
  rec_t             front_rec, back_rec;
  logic             front_valid, front_ready;
  logic             back_valid, back_pop;
  logic [LVL_W-1:0] res_level;
  logic             res_acc, res_off;

  idbc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  idbc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ev_valid_i  (s_axis_tvalid_i),
    .ev_ready_o  (s_axis_tready_o),
    .ev_kind_i   (s_axis_tuser_i),
    .ev_time_i   (s_axis_tdata_i),
    .rec_valid_o (front_valid),
    .rec_ready_i (front_ready),
    .rec_o       (front_rec)
  );

  idbc_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_rec),
    .pop_valid_o  (back_valid),
    .pop_i        (back_pop),
    .pop_data_o   (back_rec)
  );

  idbc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rec_valid_i    (back_valid),
    .rec_i          (back_rec),
    .rec_pop_o      (back_pop),
    .res_valid_o    (m_axis_tvalid_o),
    .res_ready_i    (m_axis_tready_i),
    .res_action_o   (m_axis_tuser_o),
    .res_level_o    (res_level),
    .res_accepted_o (res_acc),
    .res_off_o      (res_off),
    .res_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'b0, res_off, res_acc, res_level};

endmodule

`default_nettype wire

### sv/idbc_checker.sv
// Port-level checks of the idle controller and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module idbc_checker import idbc_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid_i,
  input wire logic        m_tready_i,
  input wire logic [23:0] m_tdata_i,
  input wire logic [2:0]  m_tuser_i,
  input wire logic        m_tlast_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result beat dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i) && $stable(m_tuser_i))
    else $error("result payload changed while stalled");

  a_none_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i == ACT_NONE |-> m_tlast_i)
    else $error("no-action result is not the only result of its event");

  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i != ACT_SET |-> m_tdata_i[15:0] == 16'd0)
    else $error("nonzero level on a non-brightness action");

  a_event_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tready_i && !m_tlast_i |=>
      !m_tvalid_i || m_tdata_i[17:16] == $past(m_tdata_i[17:16]))
    else $error("status flags changed within one event");

endmodule

bind idle_dim_blank_controller_unit idbc_checker u_idbc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);

`default_nettype wire

### test/idle_dim_blank_controller_unit_tb.sv
// Self-checking testbench for the display idle controller: directed table, then random phases.
`timescale 1ns / 1ps

module idle_dim_blank_controller_unit_tb;
  import idbc_pkg::*;

  localparam int unsigned DIM_SPAN_MS   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 38;

  typedef enum logic [1:0] {
    MODE_ON      = 2'd0,
    MODE_DIM     = 2'd1,
    MODE_OFF     = 2'd2,
    MODE_BLANKED = 2'd3
  } disp_mode_e;

  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_ACTIVITY   = 2'd1,
    KIND_SCREEN_ON  = 2'd2,
    KIND_SCREEN_OFF = 2'd3
  } event_kind_e;

  typedef struct packed {
    act_e             action;
    logic [LVL_W-1:0] level;
    logic             accepted;
    logic             scr_off;
    logic             last;
  } disp_res_t;

  typedef struct packed {
    logic             is_cfg;
    logic [2:0]       reg_idx;
    event_kind_e      kind;
    logic [63:0]      value;
    logic             typed;
    act_e             want_act;
    logic [LVL_W-1:0] want_lvl;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;  // [63:0] time_ms
  logic [1:0]  s_axis_tuser_i = '0;  // [1:0] kind
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;       // [15:0] level, [16] accepted, [17] screen_is_off
  logic [2:0]  m_axis_tuser_o;       // [2:0] action
  logic        m_axis_tlast_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block: configuration and idle state.
  cfg_t             shadow_cfg;
  disp_mode_e       mode_q;
  logic [63:0]      tick_ms;
  logic [63:0]      activity_ms;
  logic [63:0]      dim_from_ms;
  logic [LVL_W-1:0] dim_level;
  logic             dim_level_ok;
  logic [LVL_W-1:0] kept_level;
  logic             kept_ok;

  disp_res_t step_acts[$];
  disp_res_t display_actions_q[$];
  dir_row_t  dir_rows[$];

  disp_res_t seen_res;
  disp_res_t due_res;
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;

  always #1 clk_i = ~clk_i;

  idle_dim_blank_controller_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  function automatic bit off_capable();
    return shadow_cfg.timeout_feature &&
           (shadow_cfg.fb_blank_enable || shadow_cfg.has_backlight);
  endfunction

  task automatic add_action(input act_e act, input logic [LVL_W-1:0] lvl);
    disp_res_t r;
    if (step_acts.size() < MAX_RES) begin
      r = '0;
      r.action = act;
      r.level = lvl;
      step_acts.push_back(r);
    end
  endtask

  task automatic keep_brightness();
    kept_ok = shadow_cfg.has_backlight;
    kept_level = kept_ok ? shadow_cfg.brightness_setting : '0;
  endtask

  task automatic enter_off();
    if (mode_q >= MODE_OFF) return;
    if (mode_q == MODE_ON) keep_brightness();
    mode_q = MODE_OFF;
    if (shadow_cfg.has_backlight) add_action(ACT_SET, '0);
    add_action(ACT_BLANK_SCRIPT, '0);
    if (shadow_cfg.fb_blank_enable) begin
      add_action(ACT_FB_BLANK, '0);
      mode_q = MODE_BLANKED;
    end
  endtask

  task automatic wake_up();
    if (mode_q == MODE_ON) return;
    // fb unblank follows the mode, not the current fb_blank_enable
    if (mode_q == MODE_BLANKED) add_action(ACT_FB_UNBLANK, '0);
    if (mode_q >= MODE_OFF) add_action(ACT_UNBLANK_SCRIPT, '0);
    if (kept_ok) add_action(ACT_SET, kept_level);
    mode_q = MODE_ON;
    dim_from_ms = '0;
    dim_level_ok = 1'b0;
    dim_level = '0;
  endtask

  task automatic idle_tick(input logic [63:0] t);
    logic [63:0] idle_ms;
    logic [63:0] dim_ms;
    logic [63:0] steps;
    logic [31:0] ramp_top;
    logic [31:0] prog;
    logic [31:0] value;
    tick_ms = t;
    if (!off_capable()) return;
    if (activity_ms == '0) activity_ms = t;
    if (shadow_cfg.timeout_secs == '0 || mode_q >= MODE_OFF) return;
    idle_ms = (t >= activity_ms) ? t - activity_ms : 64'd0;
    if (shadow_cfg.timeout_secs > DIM_LEAD_SECS && mode_q == MODE_ON &&
        idle_ms >= 64'(shadow_cfg.timeout_secs - DIM_LEAD_SECS) * MS_PER_SEC) begin
      keep_brightness();
      mode_q = MODE_DIM;
      dim_from_ms = t;
      dim_level_ok = 1'b0;
      dim_level = '0;
    end
    if (mode_q == MODE_DIM && shadow_cfg.has_backlight) begin
      ramp_top = kept_ok ? 32'(kept_level) : 32'd0;
      if (ramp_top < DIM_FLOOR) ramp_top = DIM_FLOOR;
      dim_ms = (t >= dim_from_ms) ? t - dim_from_ms : 64'd0;
      steps = dim_ms / (DIM_SPAN_MS / PER_MILLE);
      prog = (steps > PER_MILLE) ? PER_MILLE : steps[31:0];
      value = ramp_top - (ramp_top - DIM_FLOOR) * prog / PER_MILLE;
      // write only on a change of level
      if (!dim_level_ok || value[LVL_W-1:0] != dim_level) begin
        add_action(ACT_SET, value[LVL_W-1:0]);
        dim_level = value[LVL_W-1:0];
        dim_level_ok = 1'b1;
      end
    end
    if (idle_ms >= 64'(shadow_cfg.timeout_secs) * MS_PER_SEC) enter_off();
  endtask

  // Work out the display actions of one event into step_acts.
  task automatic idle_ctrl_step(input event_kind_e kind, input logic [63:0] t);
    logic acc;
    acc = 1'b0;
    step_acts.delete();
    case (kind)
      KIND_TICK: idle_tick(t);
      KIND_ACTIVITY: begin
        if (off_capable()) begin
          if (mode_q != MODE_ON) wake_up();
          activity_ms = tick_ms;
        end
      end
      KIND_SCREEN_ON: begin
        if (off_capable()) begin
          acc = 1'b1;
          if (mode_q == MODE_ON) begin
            if (shadow_cfg.fb_blank_enable) add_action(ACT_FB_UNBLANK, '0);
            if (shadow_cfg.has_backlight) add_action(ACT_SET, shadow_cfg.brightness_setting);
          end else begin
            wake_up();
          end
          activity_ms = tick_ms;
        end
      end
      default: begin
        if (off_capable()) begin
          acc = 1'b1;
          enter_off();
        end
      end
    endcase
    if (step_acts.size() == 0) add_action(ACT_NONE, '0);
    foreach (step_acts[k]) begin
      step_acts[k].accepted = acc;
      step_acts[k].scr_off = (mode_q >= MODE_OFF);
      step_acts[k].last = (k == step_acts.size() - 1);
    end
  endtask

  function automatic dir_row_t event_row(input event_kind_e kind, input logic [63:0] t);
    dir_row_t r;
    r = '0;
    r.kind = kind;
    r.value = t;
    return r;
  endfunction

  function automatic dir_row_t checked_row(input event_kind_e kind, input logic [63:0] t,
                                           input act_e act, input logic [LVL_W-1:0] lvl);
    dir_row_t r;
    r = event_row(kind, t);
    r.typed = 1'b1;
    r.want_act = act;
    r.want_lvl = lvl;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [2:0] idx, input logic [LVL_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.value = 64'(val);
    return r;
  endfunction

  function automatic string show(input disp_res_t r);
    return $sformatf("act=%0d lvl=%0d acc=%0b off=%0b last=%0b",
                     r.action, r.level, r.accepted, r.scr_off, r.last);
  endfunction

  task automatic flag_mismatch(input string what, input disp_res_t want, input disp_res_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %s, got %s", $time, what, show(want), show(got));
  endtask

  // Offer one event beat, then predict its actions once it is taken.
  task automatic send_event(input event_kind_e kind, input logic [63:0] stamp,
                            input logic typed, input act_e want_act,
                            input logic [LVL_W-1:0] want_lvl);
    while (!calm && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= stamp;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    idle_ctrl_step(kind, stamp);
    if (typed) begin
      step_acts[0].action = want_act;
      step_acts[0].level = want_lvl;
    end
    foreach (step_acts[k]) display_actions_q.push_back(step_acts[k]);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (display_actions_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [LVL_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_TIMEOUT:    shadow_cfg.timeout_secs = val;
      REG_BRIGHTNESS: shadow_cfg.brightness_setting = val;
      REG_BACKLIGHT:  shadow_cfg.has_backlight = val[0];
      REG_FB_BLANK:   shadow_cfg.fb_blank_enable = val[0];
      REG_TIMEOUT_EN: shadow_cfg.timeout_feature = val[0];
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= calm || ($urandom_range(0, 99) >= 29);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_res.action = act_e'(m_axis_tuser_o);
      seen_res.level = m_axis_tdata_o[15:0];
      seen_res.accepted = m_axis_tdata_o[16];
      seen_res.scr_off = m_axis_tdata_o[17];
      seen_res.last = m_axis_tlast_o;
      if (display_actions_q.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, seen_res);
      end else begin
        due_res = display_actions_q.pop_front();
        if (seen_res.action !== due_res.action || seen_res.level !== due_res.level ||
            seen_res.accepted !== due_res.accepted || seen_res.scr_off !== due_res.scr_off ||
            seen_res.last !== due_res.last)
          flag_mismatch("result mismatch", due_res, seen_res);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t    row;
    event_kind_e kind;
    logic [63:0] now_ms;
    logic [63:0] stamp;
    logic [LVL_W-1:0] tmo;
    logic [LVL_W-1:0] lvl;
    int unsigned pick;
    int unsigned act_pct;

    shadow_cfg.timeout_secs = '0;
    shadow_cfg.brightness_setting = 16'd255;
    shadow_cfg.has_backlight = 1'b0;
    shadow_cfg.fb_blank_enable = 1'b1;
    shadow_cfg.timeout_feature = 1'b1;
    mode_q = MODE_ON;
    tick_ms = '0;
    activity_ms = '0;
    dim_from_ms = '0;
    dim_level = '0;
    dim_level_ok = 1'b0;
    kept_level = '0;
    kept_ok = 1'b0;

    dir_rows = '{
      checked_row(KIND_TICK, 64'd0, ACT_NONE, 16'd0),
      checked_row(KIND_ACTIVITY, 64'd0, ACT_NONE, 16'd0),
      checked_row(KIND_SCREEN_ON, 64'd0, ACT_FB_UNBLANK, 16'd0),
      checked_row(KIND_SCREEN_OFF, 64'd0, ACT_BLANK_SCRIPT, 16'd0),
      checked_row(KIND_SCREEN_OFF, 64'd0, ACT_NONE, 16'd0),
      checked_row(KIND_ACTIVITY, 64'd0, ACT_FB_UNBLANK, 16'd0),
      reg_row(REG_BACKLIGHT, 16'd1),
      reg_row(REG_TIMEOUT, 16'd3),
      reg_row(REG_BRIGHTNESS, 16'hFFFF),
      event_row(KIND_TICK, 64'd1000),
      checked_row(KIND_TICK, 64'd2000, ACT_SET, 16'hFFFF),
      event_row(KIND_TICK, 64'd3000),
      event_row(KIND_TICK, 64'd3000),
      // time steps back mid-ramp
      event_row(KIND_TICK, 64'd2500),
      // ramp ends and blanking follows in the same tick
      event_row(KIND_TICK, 64'd4000),
      checked_row(KIND_SCREEN_ON, 64'd0, ACT_FB_UNBLANK, 16'd0),
      event_row(KIND_SCREEN_ON, '1),
      reg_row(REG_TIMEOUT, 16'hFFFF),
      reg_row(REG_BRIGHTNESS, 16'd0),
      event_row(KIND_TICK, '1),
      event_row(KIND_ACTIVITY, 64'd0),
      reg_row(REG_FB_BLANK, 16'd0),
      event_row(KIND_SCREEN_OFF, 64'd0),
      event_row(KIND_SCREEN_ON, 64'd0),
      reg_row(REG_TIMEOUT_EN, 16'd0),
      checked_row(KIND_SCREEN_ON, 64'd0, ACT_NONE, 16'd0),
      event_row(KIND_TICK, 64'd5),
      reg_row(REG_TIMEOUT_EN, 16'd1),
      reg_row(REG_BACKLIGHT, 16'd0),
      checked_row(KIND_SCREEN_OFF, 64'd0, ACT_NONE, 16'd0),
      reg_row(REG_TIMEOUT, 16'd1),
      reg_row(REG_FB_BLANK, 16'd1),
      reg_row(REG_BACKLIGHT, 16'd1),
      reg_row(REG_BRIGHTNESS, 16'd100),
      event_row(KIND_TICK, 64'd10),
      event_row(KIND_ACTIVITY, 64'd0),
      event_row(KIND_TICK, 64'd1010),
      // clear fb blanking while blanked; the wake still unblanks the fb
      reg_row(REG_FB_BLANK, 16'd0),
      event_row(KIND_ACTIVITY, 64'd0)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        wait_drained();
        write_reg(row.reg_idx, row.value[LVL_W-1:0]);
      end else begin
        send_event(row.kind, row.value, row.typed, row.want_act, row.want_lvl);
      end
    end

    now_ms = 64'd20000;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case ($urandom_range(0, 9))
        0: tmo = '0;
        1: tmo = 16'($urandom_range(1, 2));
        2: tmo = 16'hFFFF;
        3: tmo = 16'($urandom);
        default: tmo = 16'($urandom_range(3, 8));
      endcase
      case ($urandom_range(0, 5))
        0: lvl = '0;
        1: lvl = 16'($urandom_range(1, 5));
        2: lvl = 16'hFFFF;
        default: lvl = 16'($urandom);
      endcase
      write_reg(REG_TIMEOUT, tmo);
      write_reg(REG_BRIGHTNESS, lvl);
      write_reg(REG_BACKLIGHT, 16'($urandom_range(0, 99) < 75));
      write_reg(REG_FB_BLANK, 16'($urandom_range(0, 99) < 70));
      write_reg(REG_TIMEOUT_EN, 16'($urandom_range(0, 99) < 90));
      calm = (ph == 3);
      act_pct = $urandom_range(0, 1) ? 2 : 8;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < act_pct) kind = KIND_ACTIVITY;
        else if (pick < act_pct + 5) kind = KIND_SCREEN_ON;
        else if (pick < act_pct + 10) kind = KIND_SCREEN_OFF;
        else kind = KIND_TICK;
        stamp = now_ms;
        if (kind == KIND_TICK) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) begin
            stamp = {$urandom, $urandom};
          end else if (pick < 8) begin
            stamp = now_ms - 64'($urandom_range(0, 3000));
          end else begin
            now_ms = now_ms + 64'($urandom_range(0, 700));
            stamp = now_ms;
          end
        end else if ($urandom_range(0, 1)) begin
          // time field is ignored here; fill it with noise
          stamp = {$urandom, $urandom};
        end
        send_event(kind, stamp, 1'b0, ACT_NONE, '0);
      end
      calm = 1'b0;
    end

    wait_drained();
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
